// File: sv/bam_pkg.sv
// ----------------------------------------------------------------------------
// Byte-addressable word memory package
// Access mode codes and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bam_pkg;

    localparam int MODE_W  = 3;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 64;
    localparam int LIMIT_W = 34;

    localparam logic [MODE_W-1:0] MODE_WORD_RD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD_WR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BYTE_RD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BYTE_WR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UWORD_RD = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UWORD_WR = 3'd5;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd0;
        logic rd1;
        logic cap0;
        logic cap1;
        logic wr0;
        logic wr1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic nop;
        logic is_write;
        logic two_words;
        logic clr_last;
    } t_status;

endpackage

// File: sv/bam_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one memory access request per transfer.
// ----------------------------------------------------------------------------
interface bam_req_if;
    logic                          valid;
    logic                          ready;
    logic [bam_pkg::MODE_W-1:0]    mode;
    logic [bam_pkg::ADDR_W-1:0]    address;
    logic [bam_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

// File: sv/bam_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one access result per transfer.
// ----------------------------------------------------------------------------
interface bam_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bam_pkg::DATA_W-1:0]    read_data;
    logic                          out_of_range;

    modport source (output valid, output read_data, output out_of_range, input ready);
    modport sink   (input valid, input read_data, input out_of_range, output ready);
endinterface

// File: sv/byte_addressable_word_memory.sv
// ----------------------------------------------------------------------------
// Byte-addressable word memory
// Little-endian store of WORDS 64-bit words with word, byte and unaligned
// eight-byte read and write access.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (mode, address, write_data) and each one yields
// exactly one result on o_rsp (read_data, out_of_range), in order.
// An access that does not lie wholly inside the store reports out_of_range,
// returns zero and leaves the store untouched; unused modes return zero.
// One request is worked on at a time through the single-port word store, and
// the next request is taken in the cycle after the result is loaded.
// A read fetches one word, or two when an unaligned access spans two words;
// a write is a read-modify-write that writes back one or two words the same
// way, and an out-of-range access or an unused mode skips the store.
// The result sits in an output register, so the next request is taken while
// a result waits; a stalled receiver only halts the block once a second
// result is ready. After reset a clearing pass writes zero to every word,
// and i_req.ready stays low until it ends.
// ----------------------------------------------------------------------------
module byte_addressable_word_memory #(
    parameter int WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bam_req_if.sink     i_req,
    bam_rsp_if.source   o_rsp
);

    bam_pkg::t_cmd    cmd;
    bam_pkg::t_status status;

    bam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bam_dp #(
        .WORDS (WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_req.mode),
        .i_address      (i_req.address),
        .i_write_data   (i_req.write_data),
        .o_read_data    (o_rsp.read_data),
        .o_out_of_range (o_rsp.out_of_range)
    );

endmodule

// File: sv/bam_ctrl.sv
// ----------------------------------------------------------------------------
// Byte-addressable word memory controller
// Sequences the clearing pass, the memory reads, the merges and the write-back
// of one access, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bam_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  bam_pkg::t_status i_status,
    output bam_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_CAP,
        S_WR0,
        S_WR1,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd0 = !i_status.nop;
                if (i_status.nop) begin
                    n_state = S_DONE;
                end else if (i_status.two_words) begin
                    n_state = S_RD1;
                end else begin
                    n_state = S_CAP;
                end
            end
            S_RD1: begin
                o_cmd.cap0 = 1'b1;
                o_cmd.rd1  = 1'b1;
                n_state    = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap0 = !i_status.two_words;
                o_cmd.cap1 = i_status.two_words;
                n_state    = i_status.is_write ? S_WR0 : S_DONE;
            end
            S_WR0: begin
                o_cmd.wr0 = 1'b1;
                n_state   = i_status.two_words ? S_WR1 : S_DONE;
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: sv/bam_dp.sv
// ----------------------------------------------------------------------------
// Byte-addressable word memory datapath
// Holds the word store, the request registers, the two-word merge buffer,
// the bounds check, the byte-lane shifter and the result register.
// ----------------------------------------------------------------------------
module bam_dp #(
    parameter int WORDS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bam_pkg::t_cmd                i_cmd,
    output bam_pkg::t_status             o_status,
    input  logic [bam_pkg::MODE_W-1:0]   i_mode,
    input  logic [bam_pkg::ADDR_W-1:0]   i_address,
    input  logic [bam_pkg::DATA_W-1:0]   i_write_data,
    output logic [bam_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_out_of_range
);

    localparam int IW = $clog2(WORDS);
    localparam logic [bam_pkg::LIMIT_W-1:0] WORD_LIMIT = bam_pkg::LIMIT_W'(WORDS);
    localparam logic [bam_pkg::LIMIT_W-1:0] BYTE_LIMIT = bam_pkg::LIMIT_W'(WORDS * 8);

    logic [63:0]                  mem [WORDS];
    logic [63:0]                  r_rdata;
    logic [IW-1:0]                r_clr_cnt;
    logic [bam_pkg::MODE_W-1:0]   r_mode;
    logic [bam_pkg::ADDR_W-1:0]   r_addr;
    logic [63:0]                  r_wdata;
    logic                         r_err;
    logic [63:0]                  r_buf_lo;
    logic [63:0]                  r_buf_hi;
    logic [63:0]                  r_out_data;
    logic                         r_out_err;

    logic [bam_pkg::LIMIT_W-1:0]  in_addr;
    logic                         in_err;
    logic                         word_mode;
    logic                         byte_mode;
    logic                         uword_mode;
    logic                         is_write;
    logic                         is_read;
    logic [2:0]                   offset;
    logic [5:0]                   shift;
    logic [IW-1:0]                idx0;
    logic [IW-1:0]                idx1;
    logic [63:0]                  lane_mask;
    logic [127:0]                 buf_word;
    logic [127:0]                 shifted;
    logic [127:0]                 mask_wide;
    logic [127:0]                 ins_wide;
    logic [127:0]                 merged;
    logic [63:0]                  extract;
    logic [IW-1:0]                mem_addr;
    logic                         mem_we;
    logic [63:0]                  mem_wdata;

    always_comb begin
        in_addr = {2'b00, i_address};
        unique case (i_mode)
            bam_pkg::MODE_WORD_RD, bam_pkg::MODE_WORD_WR: begin
                in_err = (in_addr >= WORD_LIMIT);
            end
            bam_pkg::MODE_BYTE_RD, bam_pkg::MODE_BYTE_WR: begin
                in_err = (in_addr >= BYTE_LIMIT);
            end
            bam_pkg::MODE_UWORD_RD, bam_pkg::MODE_UWORD_WR: begin
                in_err = ((in_addr + bam_pkg::LIMIT_W'(8)) > BYTE_LIMIT);
            end
            default: begin
                in_err = 1'b0;
            end
        endcase
    end

    assign word_mode  = (r_mode == bam_pkg::MODE_WORD_RD) || (r_mode == bam_pkg::MODE_WORD_WR);
    assign byte_mode  = (r_mode == bam_pkg::MODE_BYTE_RD) || (r_mode == bam_pkg::MODE_BYTE_WR);
    assign uword_mode = (r_mode == bam_pkg::MODE_UWORD_RD) ||
                        (r_mode == bam_pkg::MODE_UWORD_WR);
    assign is_write   = (r_mode == bam_pkg::MODE_WORD_WR) || (r_mode == bam_pkg::MODE_BYTE_WR) ||
                        (r_mode == bam_pkg::MODE_UWORD_WR);
    assign is_read    = (r_mode == bam_pkg::MODE_WORD_RD) || (r_mode == bam_pkg::MODE_BYTE_RD) ||
                        (r_mode == bam_pkg::MODE_UWORD_RD);

    assign offset    = word_mode ? 3'd0 : r_addr[2:0];
    assign shift     = {offset, 3'b000};
    assign idx0      = word_mode ? r_addr[IW-1:0] : r_addr[IW+2:3];
    assign idx1      = idx0 + IW'(1);
    assign lane_mask = byte_mode ? 64'h0000_0000_0000_00FF : 64'hFFFF_FFFF_FFFF_FFFF;

    assign buf_word  = {r_buf_hi, r_buf_lo};
    assign shifted   = buf_word >> shift;
    assign extract   = shifted[63:0] & lane_mask;
    assign mask_wide = {64'd0, lane_mask} << shift;
    assign ins_wide  = {64'd0, r_wdata & lane_mask} << shift;
    assign merged    = (buf_word & ~mask_wide) | ins_wide;

    assign o_status.nop       = r_err || !(word_mode || byte_mode || uword_mode);
    assign o_status.is_write  = is_write;
    assign o_status.two_words = uword_mode && (offset != 3'd0);
    assign o_status.clr_last  = (r_clr_cnt == IW'(WORDS - 1));

    always_comb begin
        priority if (i_cmd.clr) begin
            mem_addr = r_clr_cnt;
        end else if (i_cmd.rd1 || i_cmd.wr1) begin
            mem_addr = idx1;
        end else begin
            mem_addr = idx0;
        end
    end

    assign mem_we    = i_cmd.clr || i_cmd.wr0 || i_cmd.wr1;
    assign mem_wdata = i_cmd.clr ? 64'd0 : (i_cmd.wr1 ? merged[127:64] : merged[63:0]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.rd0 || i_cmd.rd1) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_err   <= in_err;
        end
        if (i_cmd.cap0) begin
            r_buf_lo <= r_rdata;
        end
        if (i_cmd.cap1) begin
            r_buf_hi <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_data <= (!r_err && is_read) ? extract : 64'd0;
            r_out_err  <= r_err;
        end
    end

    assign o_read_data    = r_out_data;
    assign o_out_of_range = r_out_err;

endmodule

// File: sv/bam_checker.sv
// ----------------------------------------------------------------------------
// Byte-addressable word memory checker
// Port-level assertions on the response channel and the clearing pass.
// ----------------------------------------------------------------------------
module bam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_read_data,
    input logic        i_out_of_range
);

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("Request accepted before the clearing pass ended.");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_of_range) |-> (i_read_data == 64'd0))
        else $error("Out-of-range result carries non-zero read data.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("Result withdrawn before its transfer.");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_read_data) && $stable(i_out_of_range)))
        else $error("Result changed while the receiver stalled.");

endmodule

bind byte_addressable_word_memory bam_checker u_bam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_read_data    (o_rsp.read_data),
    .i_out_of_range (o_rsp.out_of_range)
);

// File: dv/tb_byte_addressable_word_memory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-addressable word memory testbench
// Sends word, byte and unaligned eight-byte accesses to the memory and
// compares every result with a local image of the store that is updated in
// transfer order. Both channels pause at random, except in the final part.
// ----------------------------------------------------------------------------
module tb_byte_addressable_word_memory;

    localparam int WORDS                = 1024;
    localparam longint unsigned BYTE_LIMIT = longint'(WORDS) * 8;
    localparam int WATCHDOG_LIMIT       = 5 * (WORDS + 64);
    localparam int DRAIN_CYCLES         = 32;
    localparam int MAX_REPORTS          = 10;

    localparam logic [bam_pkg::MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [bam_pkg::MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [bam_pkg::DATA_W-1:0] read_data;
        logic                       out_of_range;
    } t_access_result;

    logic i_clk;
    logic i_rst_n;

    bam_req_if req_if ();
    bam_rsp_if rsp_if ();

    logic [bam_pkg::DATA_W-1:0] mem_image [WORDS];
    t_access_result    pending_results [$];
    int                fail_count   = 0;
    int                quiet_cycles = 0;
    bit                idling_on    = 1'b1;

    byte_addressable_word_memory #(
        .WORDS (WORDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] image_byte(input longint unsigned a);
        return mem_image[int'(a >> 3)][int'(a % 8) * 8 +: 8];
    endfunction

    function automatic void set_image_byte(input longint unsigned a, input logic [7:0] v);
        mem_image[int'(a >> 3)][int'(a % 8) * 8 +: 8] = v;
    endfunction

    function automatic t_access_result compute_access(
        input logic [bam_pkg::MODE_W-1:0] mode,
        input logic [bam_pkg::ADDR_W-1:0] address,
        input logic [bam_pkg::DATA_W-1:0] write_data);
        t_access_result  r;
        longint unsigned byte_addr;
        r = '0;
        byte_addr = address;
        unique case (mode)
            bam_pkg::MODE_WORD_RD, bam_pkg::MODE_WORD_WR: begin
                if (byte_addr >= longint'(WORDS)) begin
                    r.out_of_range = 1'b1;
                end else if (mode == bam_pkg::MODE_WORD_RD) begin
                    r.read_data = mem_image[int'(byte_addr)];
                end else begin
                    mem_image[int'(byte_addr)] = write_data;
                end
            end
            bam_pkg::MODE_BYTE_RD, bam_pkg::MODE_BYTE_WR: begin
                if (byte_addr >= BYTE_LIMIT) begin
                    r.out_of_range = 1'b1;
                end else if (mode == bam_pkg::MODE_BYTE_RD) begin
                    r.read_data[7:0] = image_byte(byte_addr);
                end else begin
                    set_image_byte(byte_addr, write_data[7:0]);
                end
            end
            bam_pkg::MODE_UWORD_RD, bam_pkg::MODE_UWORD_WR: begin
                if (byte_addr + 8 > BYTE_LIMIT) begin
                    r.out_of_range = 1'b1;
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        if (mode == bam_pkg::MODE_UWORD_RD) begin
                            r.read_data[8*i +: 8] = image_byte(byte_addr + i);
                        end else begin
                            set_image_byte(byte_addr + i, write_data[8*i +: 8]);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic [bam_pkg::DATA_W-1:0] want,
                                          input logic [bam_pkg::DATA_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        end
    endfunction

    task automatic send_access(input logic [bam_pkg::MODE_W-1:0] mode,
                               input logic [bam_pkg::ADDR_W-1:0] address,
                               input logic [bam_pkg::DATA_W-1:0] write_data);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= mode;
        req_if.address    <= address;
        req_if.write_data <= write_data;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(compute_access(mode, address, write_data));
    endtask

    task automatic send_random_access();
        logic [bam_pkg::MODE_W-1:0] mode;
        logic [bam_pkg::ADDR_W-1:0] address;
        logic [bam_pkg::DATA_W-1:0] data;
        longint unsigned   span;
        int                hot;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_UNUSED_6 : MODE_UNUSED_7;
        end else begin
            mode = bam_pkg::MODE_W'($urandom_range(bam_pkg::MODE_WORD_RD,
                                                   bam_pkg::MODE_UWORD_WR));
        end
        if (mode == bam_pkg::MODE_WORD_RD || mode == bam_pkg::MODE_WORD_WR) begin
            span = WORDS;
            hot  = 16;
        end else begin
            span = BYTE_LIMIT;
            hot  = 128;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            address = $urandom_range(0, hot - 1);
        end else if (pick < 75) begin
            address = $urandom_range(0, int'(span) - 1);
        end else if (pick < 85) begin
            address = bam_pkg::ADDR_W'(span - 10 + $urandom_range(0, 12));
        end else begin
            address = $urandom();
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            data = '0;
        end else if (pick == 1) begin
            data = '1;
        end else begin
            data = {$urandom(), $urandom()};
        end
        send_access(mode, address, data);
    endtask

    task automatic test_word_access();
        send_access(bam_pkg::MODE_WORD_WR, 32'd0, '1);
        send_access(bam_pkg::MODE_WORD_RD, 32'd0, '0);
        send_access(bam_pkg::MODE_WORD_WR, WORDS - 1, 64'h0123_4567_89AB_CDEF);
        send_access(bam_pkg::MODE_WORD_RD, WORDS - 1, '1);
        send_access(bam_pkg::MODE_WORD_WR, WORDS, 64'hDEAD_BEEF_0000_0001);
        send_access(bam_pkg::MODE_WORD_RD, WORDS, '0);
        send_access(bam_pkg::MODE_WORD_RD, 32'hFFFF_FFFF, '0);
    endtask

    task automatic test_byte_access();
        send_access(bam_pkg::MODE_BYTE_WR, 32'd0, 64'hFFFF_FFFF_FFFF_FF5A);
        send_access(bam_pkg::MODE_BYTE_RD, 32'd0, '1);
        send_access(bam_pkg::MODE_WORD_RD, 32'd0, '0);
        send_access(bam_pkg::MODE_BYTE_WR, bam_pkg::ADDR_W'(BYTE_LIMIT - 1),
                    64'h0000_0000_0000_00A5);
        send_access(bam_pkg::MODE_BYTE_RD, bam_pkg::ADDR_W'(BYTE_LIMIT - 1), '0);
        send_access(bam_pkg::MODE_BYTE_WR, bam_pkg::ADDR_W'(BYTE_LIMIT), '1);
        send_access(bam_pkg::MODE_BYTE_RD, 32'hFFFF_FFFF, '0);
    endtask

    task automatic test_unaligned_access();
        send_access(bam_pkg::MODE_UWORD_WR, 32'd13, 64'h8877_6655_4433_2211);
        send_access(bam_pkg::MODE_UWORD_RD, 32'd13, '0);
        send_access(bam_pkg::MODE_WORD_RD, 32'd1, '0);
        send_access(bam_pkg::MODE_WORD_RD, 32'd2, '0);
        send_access(bam_pkg::MODE_UWORD_WR, bam_pkg::ADDR_W'(BYTE_LIMIT - 8), '1);
        send_access(bam_pkg::MODE_UWORD_RD, bam_pkg::ADDR_W'(BYTE_LIMIT - 8), '0);
        send_access(bam_pkg::MODE_UWORD_RD, bam_pkg::ADDR_W'(BYTE_LIMIT - 7), '0);
        send_access(bam_pkg::MODE_UWORD_WR, 32'hFFFF_FFF9, 64'h0102_0304_0506_0708);
        send_access(bam_pkg::MODE_UWORD_RD, 32'd16, '0);
    endtask

    task automatic test_unused_modes();
        send_access(MODE_UNUSED_6, 32'd0, '1);
        send_access(MODE_UNUSED_7, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_access();
    endtask

    // The receiver keeps ready high and requests are sent without idle gaps.
    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count) send_random_access();
    endtask

    initial begin
        int n;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idling_on && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 8);
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            n = $urandom_range(1, 12);
            rsp_if.ready <= 1'b1;
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, rsp_if.read_data);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.read_data !== want.read_data) begin
                    note_mismatch("read_data", want.read_data, rsp_if.read_data);
                end
                if (rsp_if.out_of_range !== want.out_of_range) begin
                    note_mismatch("out_of_range", bam_pkg::DATA_W'(want.out_of_range),
                                  bam_pkg::DATA_W'(rsp_if.out_of_range));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        foreach (mem_image[i]) mem_image[i] = '0;
        req_if.valid      <= 1'b0;
        req_if.mode       <= bam_pkg::MODE_WORD_RD;
        req_if.address    <= '0;
        req_if.write_data <= '0;
        i_rst_n           <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_word_access();
        test_byte_access();
        test_unaligned_access();
        test_unused_modes();
        test_random_mix(650);
        test_back_to_back(150);

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
